// ===== rtl/rsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and character codes for the regex syntax checker.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int CH_W          = 8;
    localparam int TDATA_OUT_W   = 8;
    localparam int MAX_DEPTH_DEF = 255;

    localparam logic [CH_W-1:0] CH_END       = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CH_W-1:0] CH_LPAREN    = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN    = 8'h29;
    localparam logic [CH_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [CH_W-1:0] CH_PLUS      = 8'h2B;
    localparam logic [CH_W-1:0] CH_DOT       = 8'h2E;
    localparam logic [CH_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [CH_W-1:0] CH_CARET     = 8'h5E;
    localparam logic [CH_W-1:0] CH_LOWER_N   = 8'h6E;
    localparam logic [CH_W-1:0] CH_LOWER_T   = 8'h74;
    localparam logic [CH_W-1:0] CH_BAR       = 8'h7C;

    // what the next byte must be
    typedef enum logic [2:0] {
        EXP_MUST_NOT_CLOSER = 3'b001,
        EXP_MUST_CLOSER     = 3'b010,
        EXP_FREE            = 3'b100
    } expect_t;

    typedef enum logic [3:0] {
        MODE_NORMAL      = 4'b0001,
        MODE_ESCAPE      = 4'b0010,
        MODE_BRACKET     = 4'b0100,
        MODE_BRACKET_ESC = 4'b1000
    } mode_t;

endpackage : rsc_pkg
`default_nettype wire

// ===== rtl/regex_syntax_checker.sv =====
`default_nettype none
// The result of an accepted byte is registered and is shown on the m_ side in the cycle after.
// Throughput: one byte per cycle; the scan state and the result register
// update together, and a held result only stalls the input when m_tready is low.
// Reset (aresetn low, synchronous): scan state cleared, result register empty.
// The end byte (zero) returns all scan state to its reset values.
// ----------------------------------------------------------------------------
// regex_syntax_checker
// Streaming syntax check of an extended regular expression, one byte per
// request, with a verdict on every byte and a final verdict on the end byte.
// ----------------------------------------------------------------------------
module regex_syntax_checker #(
    parameter int MAX_DEPTH = rsc_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rsc_pkg::CH_W-1:0]        s_tdata,   // [7:0] ch
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rsc_pkg::TDATA_OUT_W-1:0]      m_tdata,   // [0] invalid, [7:1] zero
    output logic                                 m_tlast    // done_res
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

    rsc_pkg::expect_t           exp_reg, exp_next;
    rsc_pkg::mode_t             mode_reg, mode_next;
    logic [DEPTH_W-1:0]         depth_reg, depth_next;
    logic                       err_reg, err_next;
    logic                       out_valid_reg;
    logic                       out_invalid_reg, out_invalid_next;
    logic                       out_done_reg, out_done_next;

    logic                       s_accept;
    logic                       is_end;
    logic                       is_closer;
    logic                       esc_ok;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign is_end    = (s_tdata == rsc_pkg::CH_END);
    assign is_closer = is_end || (s_tdata == rsc_pkg::CH_RPAREN) ||
                       (s_tdata == rsc_pkg::CH_BAR) || (s_tdata == rsc_pkg::CH_PLUS) ||
                       (s_tdata == rsc_pkg::CH_STAR);

    always_comb begin
        esc_ok = 1'b0;
        if (s_tdata inside {rsc_pkg::CH_BACKSLASH, rsc_pkg::CH_PLUS, rsc_pkg::CH_BAR,
                            rsc_pkg::CH_STAR, rsc_pkg::CH_LPAREN, rsc_pkg::CH_RPAREN,
                            rsc_pkg::CH_LBRACKET, rsc_pkg::CH_RBRACKET, rsc_pkg::CH_DOT,
                            rsc_pkg::CH_CARET, rsc_pkg::CH_LOWER_N, rsc_pkg::CH_LOWER_T,
                            rsc_pkg::CH_SPACE}) begin
            esc_ok = 1'b1;
        end
    end

    always_comb begin
        exp_next         = exp_reg;
        mode_next        = mode_reg;
        depth_next       = depth_reg;
        err_next         = err_reg;
        out_done_next    = 1'b0;
        out_invalid_next = 1'b0;

        if (is_end) begin
            out_invalid_next = err_reg || (mode_reg != rsc_pkg::MODE_NORMAL) ||
                               (exp_reg != rsc_pkg::EXP_MUST_CLOSER) ||
                               (depth_reg != '0);
            out_done_next    = 1'b1;
            exp_next         = rsc_pkg::EXP_MUST_NOT_CLOSER;
            mode_next        = rsc_pkg::MODE_NORMAL;
            depth_next       = '0;
            err_next         = 1'b0;
        end else begin
            case (mode_reg)
                rsc_pkg::MODE_NORMAL: begin
                    if ((exp_reg == rsc_pkg::EXP_MUST_NOT_CLOSER) && is_closer) begin
                        err_next = 1'b1;
                    end
                    if ((exp_reg == rsc_pkg::EXP_MUST_CLOSER) && !is_closer) begin
                        err_next = 1'b1;
                    end
                    case (s_tdata)
                        rsc_pkg::CH_LPAREN: begin
                            if (depth_reg >= DEPTH_MAX) begin
                                err_next = 1'b1;
                            end else begin
                                depth_next = depth_reg + DEPTH_W'(1);
                            end
                            exp_next = rsc_pkg::EXP_MUST_NOT_CLOSER;
                        end
                        rsc_pkg::CH_RPAREN: begin
                            if (depth_reg == '0) begin
                                err_next = 1'b1;
                            end else begin
                                depth_next = depth_reg - DEPTH_W'(1);
                            end
                            exp_next = rsc_pkg::EXP_MUST_CLOSER;
                        end
                        rsc_pkg::CH_PLUS, rsc_pkg::CH_BAR: begin
                            exp_next = rsc_pkg::EXP_MUST_NOT_CLOSER;
                        end
                        rsc_pkg::CH_BACKSLASH: begin
                            mode_next = rsc_pkg::MODE_ESCAPE;
                            exp_next  = rsc_pkg::EXP_FREE;
                        end
                        rsc_pkg::CH_LBRACKET: begin
                            mode_next = rsc_pkg::MODE_BRACKET;
                            exp_next  = rsc_pkg::EXP_FREE;
                        end
                        default: begin
                            exp_next = rsc_pkg::EXP_MUST_CLOSER;
                        end
                    endcase
                end
                rsc_pkg::MODE_ESCAPE: begin
                    if (!esc_ok) begin
                        err_next = 1'b1;
                    end
                    mode_next = rsc_pkg::MODE_NORMAL;
                    exp_next  = rsc_pkg::EXP_MUST_CLOSER;
                end
                rsc_pkg::MODE_BRACKET: begin
                    if (s_tdata == rsc_pkg::CH_RBRACKET) begin
                        mode_next = rsc_pkg::MODE_NORMAL;
                        exp_next  = rsc_pkg::EXP_MUST_CLOSER;
                    end else if (s_tdata == rsc_pkg::CH_BACKSLASH) begin
                        mode_next = rsc_pkg::MODE_BRACKET_ESC;
                    end
                end
                default: begin
                    if (!esc_ok) begin
                        err_next = 1'b1;
                    end
                    mode_next = rsc_pkg::MODE_BRACKET;
                end
            endcase
            out_invalid_next = err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg       <= rsc_pkg::EXP_MUST_NOT_CLOSER;
            mode_reg      <= rsc_pkg::MODE_NORMAL;
            depth_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                exp_reg   <= exp_next;
                mode_reg  <= mode_next;
                depth_reg <= depth_next;
                err_reg   <= err_next;
            end
            if (s_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_invalid_reg <= out_invalid_next;
            out_done_reg    <= out_done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rsc_pkg::TDATA_OUT_W-1){1'b0}}, out_invalid_reg};
    assign m_tlast  = out_done_reg;

    // end byte returns the scan state to reset
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_end) |=> (depth_reg == '0) && !err_reg &&
                                 (mode_reg == rsc_pkg::MODE_NORMAL) &&
                                 (exp_reg == rsc_pkg::EXP_MUST_NOT_CLOSER))
        else $error("scan state not cleared after end byte");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_MAX)
        else $error("paren depth above limit");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg && !(s_accept && is_end)) |=> err_reg)
        else $error("error latch dropped before end byte");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    a_bracket_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != rsc_pkg::MODE_NORMAL) |-> (exp_reg == rsc_pkg::EXP_FREE) ||
                                               (mode_reg == rsc_pkg::MODE_BRACKET &&
                                                exp_reg == rsc_pkg::EXP_FREE))
        else $error("expectation not free outside normal mode");

endmodule : regex_syntax_checker
`default_nettype wire

// ===== sim/tb_regex_syntax_checker.sv =====
// ----------------------------------------------------------------------------
// tb_regex_syntax_checker
// Streams expression bytes into the syntax checker. Each accepted request is
// scored by a local scan predictor, and every result is matched in order
// against the predicted error flag and end marker. The stimulus has three
// parts: directed corner strings, deep nesting at and past the depth limit,
// and random well-formed, corrupted and noise strings. Both sides idle in
// random bursts.
// ----------------------------------------------------------------------------
module tb_regex_syntax_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_pkg::*;

    localparam int DEPTH_LIMIT = MAX_DEPTH_DEF;
    localparam int ITEM_GOAL   = 2000;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 10;
    localparam int QUIET_LEFT  = 150;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            hold;
    } req_t;

    typedef struct packed {
        logic [TDATA_OUT_W-1:0] tdata;
        logic                   tlast;
    } verdict_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CH_W-1:0]        s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    req_t     pend_q[$];
    verdict_t verdict_q[$];
    bit       hold_next = 1'b0;
    int       n_sent    = 0;
    int       n_recv    = 0;
    int       err_cnt   = 0;
    int       s_gap     = 0;
    int       m_gap     = 0;
    int       idle_pct  = 0;
    bit       quiet     = 1'b0;
    int       cyc       = 0;
    int       stall_cnt = 0;

    // scan state of the predictor
    expect_t  want_st   = EXP_MUST_NOT_CLOSER;
    mode_t    mode_st   = MODE_NORMAL;
    int       paren_lvl = 0;
    bit       err_latch = 1'b0;

    logic [CH_W-1:0] esc_chars [13] = '{CH_BACKSLASH, CH_PLUS, CH_BAR, CH_STAR, CH_LPAREN,
                                        CH_RPAREN, CH_LBRACKET, CH_RBRACKET, CH_DOT,
                                        CH_CARET, CH_LOWER_N, CH_LOWER_T, CH_SPACE};

    regex_syntax_checker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] ch
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [0] invalid, [7:1] zero
        .m_tlast  (m_tlast)     // done_res
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit esc_ok(input logic [CH_W-1:0] c);
        bit hit;
        hit = 1'b0;
        foreach (esc_chars[i])
            if (esc_chars[i] == c)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic verdict_t check_char(input logic [CH_W-1:0] c);
        verdict_t v;
        logic     bad;
        bit       closer;
        v = '0;
        if (c == CH_END) begin
            bad = err_latch || mode_st != MODE_NORMAL || want_st != EXP_MUST_CLOSER ||
                  paren_lvl != 0;
            v.tdata[0] = bad;
            v.tlast    = 1'b1;
            want_st    = EXP_MUST_NOT_CLOSER;
            mode_st    = MODE_NORMAL;
            paren_lvl  = 0;
            err_latch  = 1'b0;
            return v;
        end
        case (mode_st)
            MODE_NORMAL: begin
                closer = c == CH_RPAREN || c == CH_BAR || c == CH_PLUS || c == CH_STAR;
                if (want_st == EXP_MUST_NOT_CLOSER && closer)
                    err_latch = 1'b1;
                if (want_st == EXP_MUST_CLOSER && !closer)
                    err_latch = 1'b1;
                case (c)
                    CH_LPAREN: begin
                        if (paren_lvl >= DEPTH_LIMIT)
                            err_latch = 1'b1;
                        else
                            paren_lvl++;
                        want_st = EXP_MUST_NOT_CLOSER;
                    end
                    CH_RPAREN: begin
                        if (paren_lvl == 0)
                            err_latch = 1'b1;
                        else
                            paren_lvl--;
                        want_st = EXP_MUST_CLOSER;
                    end
                    CH_PLUS, CH_BAR: want_st = EXP_MUST_NOT_CLOSER;
                    CH_BACKSLASH: begin
                        mode_st = MODE_ESCAPE;
                        want_st = EXP_FREE;
                    end
                    CH_LBRACKET: begin
                        mode_st = MODE_BRACKET;
                        want_st = EXP_FREE;
                    end
                    default: want_st = EXP_MUST_CLOSER;
                endcase
            end
            MODE_ESCAPE: begin
                if (!esc_ok(c))
                    err_latch = 1'b1;
                mode_st = MODE_NORMAL;
                want_st = EXP_MUST_CLOSER;
            end
            MODE_BRACKET: begin
                if (c == CH_RBRACKET) begin
                    mode_st = MODE_NORMAL;
                    want_st = EXP_MUST_CLOSER;
                end else if (c == CH_BACKSLASH) begin
                    mode_st = MODE_BRACKET_ESC;
                end
            end
            default: begin
                if (!esc_ok(c))
                    err_latch = 1'b1;
                mode_st = MODE_BRACKET;
            end
        endcase
        v.tdata[0] = err_latch;
        return v;
    endfunction

    task automatic put(input logic [CH_W-1:0] c);
        req_t r;
        r.ch      = c;
        r.hold    = hold_next;
        hold_next = 1'b0;
        pend_q.push_back(r);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
        put(CH_END);
    endtask

    function automatic logic [CH_W-1:0] plain_char();
        logic [CH_W-1:0] c;
        do
            c = CH_W'($urandom_range(1, 255));
        while (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACKET || c == CH_BACKSLASH ||
               c == CH_BAR || c == CH_PLUS || c == CH_STAR);
        return c;
    endfunction

    task automatic put_deep(input int n);
        repeat (n) put(CH_LPAREN);
        put(plain_char());
        repeat (n) put(CH_RPAREN);
        put(CH_END);
    endtask

    // atoms joined by + or |, optional stars, random nesting
    task automatic put_regex(input int max_open);
        int              lvl;
        int              n;
        int              len;
        bit              need;
        logic [CH_W-1:0] c;
        lvl  = 0;
        n    = 0;
        need = 1'b1;
        len  = $urandom_range(1, 6);
        while (1) begin
            if (need) begin
                while (lvl < max_open && $urandom_range(0, 3) == 0) begin
                    put(CH_LPAREN);
                    lvl++;
                end
                case ($urandom_range(0, 3))
                    0: begin
                        put(CH_BACKSLASH);
                        put(esc_chars[4'($urandom_range(0, 12))]);
                    end
                    1: begin
                        put(CH_LBRACKET);
                        repeat ($urandom_range(0, 3)) begin
                            if ($urandom_range(0, 4) == 0) begin
                                put(CH_BACKSLASH);
                                put(esc_chars[4'($urandom_range(0, 12))]);
                            end else begin
                                do
                                    c = CH_W'($urandom_range(1, 255));
                                while (c == CH_RBRACKET || c == CH_BACKSLASH);
                                put(c);
                            end
                        end
                        put(CH_RBRACKET);
                    end
                    default: put(plain_char());
                endcase
                need = 1'b0;
                n++;
            end
            if ($urandom_range(0, 2) == 0)
                put(CH_STAR);
            if (lvl > 0 && (n >= len || $urandom_range(0, 1) == 1)) begin
                put(CH_RPAREN);
                lvl--;
            end else if (n < len) begin
                put($urandom_range(0, 1) ? CH_PLUS : CH_BAR);
                need = 1'b1;
            end else begin
                break;
            end
        end
        put(CH_END);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_gap    <= 0;
        end else begin
            quiet <= pend_q.size() < QUIET_LEFT;
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap    <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pend_q[0].hold && (n_sent != n_recv || (s_tvalid && s_tready))) begin
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                    s_gap    <= $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pend_q[0].ch;
                    pend_q.pop_front();
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap    <= 0;
        end else if (m_gap > 0) begin
            m_gap    <= m_gap - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            m_gap    <= $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tlast=%b", $time, m_tdata, m_tlast);
                    err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata !== want.tdata || m_tlast !== want.tlast) begin
                        $display("%0t: mismatch expected tdata=%h tlast=%b, actual tdata=%h tlast=%b",
                                 $time, want.tdata, want.tlast, m_tdata, m_tlast);
                        err_cnt++;
                    end
                end
                n_recv <= n_recv + 1;
            end
            if (s_tvalid && s_tready) begin
                verdict_q.push_back(check_char(s_tdata));
                n_sent <= n_sent + 1;
            end
        end
    end

    // watchdog and idle rate
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 64 == 0) begin
            case ($urandom_range(0, 2))
                0:       idle_pct <= 0;
                1:       idle_pct <= 10;
                default: idle_pct <= 35;
            endcase
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("tb_regex_syntax_checker: errors");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        int   idx;
        int   pos;
        int   kind;
        req_t r;

        put_str("");
        put_str(")");
        put_str("(a");
        put_str("[a");
        put_str("\\");
        put_str("\\q");
        put_str("(a)*");
        put_str("[\\nx]");
        put(8'h01);
        put(CH_END);
        put(8'hFF);
        put(CH_END);

        idx = 0;
        while (pend_q.size() < ITEM_GOAL) begin
            if (idx % 15 == 7)
                hold_next = 1'b1;
            if (idx == 20) begin
                put_deep(DEPTH_LIMIT);
            end else if (idx == 70) begin
                put_deep(DEPTH_LIMIT + 1);
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    pos = pend_q.size();
                    put_regex($urandom_range(0, 4));
                    if (kind >= 62) begin
                        pos = $urandom_range(pos, pend_q.size() - 2);
                        case ($urandom_range(0, 2))
                            0: pend_q[pos].ch = CH_W'($urandom_range(0, 255));
                            1: pend_q.delete(pos);
                            default: begin
                                r.ch   = CH_W'($urandom_range(0, 255));
                                r.hold = 1'b0;
                                pend_q.insert(pos, r);
                            end
                        endcase
                    end
                end else begin
                    repeat ($urandom_range(0, 10))
                        put($urandom_range(0, 1) ? esc_chars[4'($urandom_range(0, 12))]
                                                 : CH_W'($urandom_range(0, 255)));
                    put(CH_END);
                end
            end
            idx++;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (pend_q.size() != 0 || s_tvalid || n_sent != n_recv)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("tb_regex_syntax_checker: clean");
        end else begin
            $display("tb_regex_syntax_checker: errors");
        end
        $finish;
    end

endmodule
